// ----- src/priority_schedule_timing_core_assert.svh -----
// Assertion macros used by the port-level checker of the priority schedule timing core.
`ifndef PRIORITY_SCHEDULE_TIMING_CORE_ASSERT_SVH
`define PRIORITY_SCHEDULE_TIMING_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, quiet while arst_n is low.
`define PST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, quiet while arst_n is low.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pst_pkg.sv -----
// Shared widths, record type and sequencer states of the priority schedule timing core.
`timescale 1ns / 1ps

package pst_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int ID_W    = 5;
	localparam int TIME_W  = 20;
	localparam int SUM_W   = 24;
	localparam int STEP_W  = $clog2(SUM_W);

	// One stored process record.
	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
		logic [ID_W-1:0]    id;
	} rec_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_SUM,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

// ----- src/priority_schedule_timing_core.sv -----
// Non-preemptive priority scheduler: record store, in-memory selection sort and timing results.
`timescale 1ns / 1ps

// Loads process records one beat per cycle while in its load state into a
// single-port-write, registered-read record memory, numbering them 1 upward. A record
// marked last, or the record that fills the store, starts the schedule: a selection
// sort over the memory (skipped for a single record; one read per cycle during each
// scan, then two writes to swap), a pass that sums waiting and turnaround times, two
// bit-serial divisions for the averages, and finally one result beat per process in
// priority order (lowest value first, ties kept as the swap order leaves them). The
// work after the last record is set mostly by the scans of the sort, which read the
// memory once per entry; results then follow one by one, held while the receiver stalls.
// No record is accepted from the last record until the final result sits in the
// output register; loading of the next set starts while that beat still waits.
module priority_schedule_timing_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// record channel
	input  logic                        rec_valid,
	output logic                        rec_ready,
	input  logic [pst_pkg::BURST_W-1:0] burst_len,
	input  logic [pst_pkg::PRIO_W-1:0]  priority_level,
	input  logic                        last_process,
	// result channel
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [pst_pkg::ID_W-1:0]    process_id,
	output logic [pst_pkg::BURST_W-1:0] burst_out,
	output logic [pst_pkg::TIME_W-1:0]  waiting_time,
	output logic [pst_pkg::TIME_W-1:0]  turnaround_time,
	output logic [pst_pkg::TIME_W-1:0]  avg_waiting,
	output logic [pst_pkg::TIME_W-1:0]  avg_turnaround,
	output logic                        last_result
);

	import pst_pkg::*;

	// Sequencer and load control.
	state_t             state_q, state_nx;
	logic [CNT_W-1:0]   count_q;     // records loaded in the current set
	logic [CNT_W-1:0]   n_q;         // size of the set being scheduled
	logic [CNT_W-1:0]   i_q;         // sort pass (slot being filled)
	logic [CNT_W-1:0]   j_q;         // memory read address counter
	logic               vld_s1;      // read data of the previous address is valid
	logic [IDX_W-1:0]   idx_s1;      // address that produced rd_data_q

	// Record memory.
	rec_t               mem_q [MAX_PROCS];
	rec_t               rd_data_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	rec_t               mem_wd;
	logic [IDX_W-1:0]   rd_addr;

	// Sort scan.
	rec_t               cur_rec_q;   // record found in slot i at the start of a pass
	rec_t               best_rec_q;  // lowest priority seen so far in the pass
	logic [IDX_W-1:0]   best_idx_q;

	// Timing sums and division.
	logic [SUM_W-1:0]   wait_q;
	logic [SUM_W-1:0]   wtot_q;
	logic [SUM_W-1:0]   ttot_q;
	logic [SUM_W-1:0]   dvd_q;       // dividend shifting out, quotient shifting in
	logic [CNT_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               div_sel_q;   // 0: waiting average, 1: turnaround average
	logic [TIME_W-1:0]  avg_w_q;
	logic [TIME_W-1:0]  avg_t_q;

	// Output register.
	logic               res_valid_q;
	logic [ID_W-1:0]    process_id_q;
	logic [BURST_W-1:0] burst_out_q;
	logic [TIME_W-1:0]  waiting_time_q;
	logic [TIME_W-1:0]  turnaround_time_q;
	logic [TIME_W-1:0]  avg_waiting_q;
	logic [TIME_W-1:0]  avg_turnaround_q;
	logic               last_result_q;

	// Decode.
	logic               rec_acc;
	logic               rec_last;
	logic               scan_done;
	logic               sort_done;
	logic               emit_fin;
	logic               load_ok;
	logic               div_end;
	logic [SUM_W-1:0]   tat;
	logic [CNT_W:0]     trial;
	logic [CNT_W:0]     diff;
	logic               div_ge;
	logic [CNT_W-1:0]   rem_nx;
	logic [SUM_W-1:0]   quo_nx;

	assign rec_acc   = rec_valid && rec_ready;
	// The record that fills the store closes the set even without its mark.
	assign rec_last  = last_process || (count_q == CNT_W'(MAX_PROCS - 1));
	assign scan_done = (j_q == n_q) && !vld_s1;
	// Stop after the pass for slot n-2: the final slot then holds the largest value.
	assign sort_done = ({1'b0, i_q} + (CNT_W + 1)'(2)) >= {1'b0, n_q};
	assign emit_fin  = (j_q + CNT_W'(1)) == n_q;
	assign load_ok   = !res_valid_q || res_ready;
	assign div_end   = step_q == STEP_W'(SUM_W - 1);
	assign tat       = wait_q + SUM_W'(rd_data_q.burst);
	assign rd_addr   = j_q[IDX_W-1:0];

	// One restoring division step: remainder stays below n, so CNT_W bits hold it.
	assign trial  = {rem_q, dvd_q[SUM_W-1]};
	assign diff   = trial - {1'b0, n_q};
	assign div_ge = trial >= {1'b0, n_q};
	assign rem_nx = div_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	assign quo_nx = {dvd_q[SUM_W-2:0], div_ge};

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (rec_acc && rec_last) begin
					state_nx = (count_q == '0) ? ST_SUM : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nx = ST_SWAP_A;
				end
			end
			ST_SWAP_A: state_nx = ST_SWAP_B;
			ST_SWAP_B: state_nx = sort_done ? ST_SUM : ST_SCAN;
			ST_SUM: begin
				if (scan_done) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_end && div_sel_q) begin
					state_nx = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: state_nx = ST_EMIT_LD;
			ST_EMIT_LD: begin
				if (load_ok) begin
					state_nx = emit_fin ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	// Handshake and memory write port.
	always_comb begin
		rec_ready = state_q == ST_LOAD;
		mem_we    = 1'b0;
		mem_wa    = count_q[IDX_W-1:0];
		mem_wd    = '{prio: priority_level, burst: burst_len,
			id: ID_W'(count_q + CNT_W'(1))};
		unique case (state_q)
			ST_LOAD: begin
				mem_we = rec_acc;
			end
			ST_SWAP_A: begin
				// move the winner into the slot of this pass
				mem_we = 1'b1;
				mem_wa = i_q[IDX_W-1:0];
				mem_wd = best_rec_q;
			end
			ST_SWAP_B: begin
				// move the displaced record where the winner was
				mem_we = 1'b1;
				mem_wa = best_idx_q;
				mem_wd = cur_rec_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Record memory: one write and one registered read per cycle. The sequencer never
	// reads an entry in the cycle it is written, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (rec_acc) begin
				count_q <= rec_last ? '0 : count_q + CNT_W'(1);
			end
			// A read is in flight whenever a scan or sum pass issues an address.
			vld_s1 <= ((state_q == ST_SCAN) || (state_q == ST_SUM)) && (j_q < n_q);
			if ((state_q == ST_EMIT_LD) && load_ok) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (rec_acc && rec_last) begin
					n_q    <= count_q + CNT_W'(1);
					i_q    <= '0;
					j_q    <= '0;
					wait_q <= '0;
					wtot_q <= '0;
					ttot_q <= '0;
				end
			end
			ST_SCAN: begin
				if (j_q < n_q) begin
					j_q    <= j_q + CNT_W'(1);
					idx_s1 <= j_q[IDX_W-1:0];
				end
				if (vld_s1) begin
					if (idx_s1 == i_q[IDX_W-1:0]) begin
						cur_rec_q  <= rd_data_q;
						best_rec_q <= rd_data_q;
						best_idx_q <= idx_s1;
					end else if (rd_data_q.prio < best_rec_q.prio) begin
						best_rec_q <= rd_data_q;
						best_idx_q <= idx_s1;
					end
				end
			end
			ST_SWAP_A: begin
				i_q <= i_q;
			end
			ST_SWAP_B: begin
				i_q <= i_q + CNT_W'(1);
				j_q <= sort_done ? '0 : i_q + CNT_W'(1);
			end
			ST_SUM: begin
				if (j_q < n_q) begin
					j_q <= j_q + CNT_W'(1);
				end
				if (vld_s1) begin
					wtot_q <= wtot_q + wait_q;
					ttot_q <= ttot_q + tat;
					wait_q <= tat;
				end
				if (scan_done) begin
					dvd_q     <= wtot_q;
					rem_q     <= '0;
					step_q    <= '0;
					div_sel_q <= 1'b0;
				end
			end
			ST_DIV: begin
				if (div_end) begin
					rem_q  <= '0;
					step_q <= '0;
					if (!div_sel_q) begin
						avg_w_q   <= quo_nx[TIME_W-1:0];
						dvd_q     <= ttot_q;
						div_sel_q <= 1'b1;
					end else begin
						avg_t_q <= quo_nx[TIME_W-1:0];
						j_q     <= '0;
						wait_q  <= '0;
					end
				end else begin
					dvd_q  <= quo_nx;
					rem_q  <= rem_nx;
					step_q <= step_q + STEP_W'(1);
				end
			end
			ST_EMIT_RD: begin
				j_q <= j_q;
			end
			ST_EMIT_LD: begin
				if (load_ok) begin
					process_id_q      <= rd_data_q.id;
					burst_out_q       <= rd_data_q.burst;
					waiting_time_q    <= wait_q[TIME_W-1:0];
					turnaround_time_q <= tat[TIME_W-1:0];
					avg_waiting_q     <= emit_fin ? avg_w_q : '0;
					avg_turnaround_q  <= emit_fin ? avg_t_q : '0;
					last_result_q     <= emit_fin;
					wait_q            <= tat;
					j_q               <= j_q + CNT_W'(1);
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	assign res_valid       = res_valid_q;
	assign process_id      = process_id_q;
	assign burst_out       = burst_out_q;
	assign waiting_time    = waiting_time_q;
	assign turnaround_time = turnaround_time_q;
	assign avg_waiting     = avg_waiting_q;
	assign avg_turnaround  = avg_turnaround_q;
	assign last_result     = last_result_q;

endmodule

// ----- src/pst_checker.sv -----
// Port-level checker for the priority schedule timing core, bound to the top level.
`timescale 1ns / 1ps
`include "priority_schedule_timing_core_assert.svh"

module pst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rec_valid,
	input logic                        rec_ready,
	input logic [pst_pkg::BURST_W-1:0] burst_len,
	input logic [pst_pkg::PRIO_W-1:0]  priority_level,
	input logic                        last_process,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [pst_pkg::ID_W-1:0]    process_id,
	input logic [pst_pkg::BURST_W-1:0] burst_out,
	input logic [pst_pkg::TIME_W-1:0]  waiting_time,
	input logic [pst_pkg::TIME_W-1:0]  turnaround_time,
	input logic [pst_pkg::TIME_W-1:0]  avg_waiting,
	input logic [pst_pkg::TIME_W-1:0]  avg_turnaround,
	input logic                        last_result
);

	import pst_pkg::*;

	logic                           rec_wait;
	logic                           res_wait;
	logic [BURST_W+PRIO_W:0]        rec_beat;
	logic [ID_W+BURST_W+4*TIME_W:0] res_beat;
	logic [TIME_W-1:0]              tat_sum;
	logic                           avg_clear;

	assign rec_wait  = rec_valid && !rec_ready;
	assign res_wait  = res_valid && !res_ready;
	assign rec_beat  = {burst_len, priority_level, last_process};
	assign res_beat  = {process_id, burst_out, waiting_time, turnaround_time, avg_waiting,
		avg_turnaround, last_result};
	assign tat_sum   = waiting_time + TIME_W'(burst_out);
	assign avg_clear = (avg_waiting == '0) && (avg_turnaround == '0);

	// hold a stalled record beat
	`PST_ASSERT_NEXT(a_rec_hold, rec_wait, rec_valid && $stable(rec_beat), "record beat moved")
	// hold a stalled result beat
	`PST_ASSERT_NEXT(a_res_hold, res_wait, res_valid, "result beat dropped")
	`PST_ASSERT_NEXT(a_res_stable, res_wait, $stable(res_beat), "stalled result changed")
	// turnaround is the waiting time plus the own burst
	`PST_ASSERT_NOW(a_tat_sum, res_valid, turnaround_time == tat_sum, "turnaround mismatch")
	// averages appear only on the final beat of a schedule
	`PST_ASSERT_NOW(a_avg_zero, res_valid && !last_result, avg_clear, "average on inner beat")

endmodule

bind priority_schedule_timing_core pst_checker u_pst_checker (.*);

// ----- bench/priority_schedule_timing_core_checker.sv -----
// Channel monitor and schedule predictor for the priority schedule timing core bench.
`timescale 1ns / 1ps

module priority_schedule_timing_core_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rec_valid,
	input  logic                        rec_ready,
	input  logic [pst_pkg::BURST_W-1:0] burst_len,
	input  logic [pst_pkg::PRIO_W-1:0]  priority_level,
	input  logic                        last_process,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [pst_pkg::ID_W-1:0]    process_id,
	input  logic [pst_pkg::BURST_W-1:0] burst_out,
	input  logic [pst_pkg::TIME_W-1:0]  waiting_time,
	input  logic [pst_pkg::TIME_W-1:0]  turnaround_time,
	input  logic [pst_pkg::TIME_W-1:0]  avg_waiting,
	input  logic [pst_pkg::TIME_W-1:0]  avg_turnaround,
	input  logic                        last_result,
	input  logic                        end_of_test,
	output int                          mismatches,
	output int                          results_owed
);
	import pst_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  waiting;
		logic [TIME_W-1:0]  turnaround;
		logic [TIME_W-1:0]  avg_wait;
		logic [TIME_W-1:0]  avg_turn;
		logic               last;
	} sched_beat_t;

	logic [BURST_W-1:0] burst_slot [MAX_PROCS];
	logic [PRIO_W-1:0]  prio_slot  [MAX_PROCS];
	logic [ID_W-1:0]    id_slot    [MAX_PROCS];
	int                 loaded = 0;

	sched_beat_t        schedule_q[$];
	sched_beat_t        head;

	initial mismatches = 0;

	task automatic note_failure(input string msg);
		$display("%0t ns: schedule check: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] got,
		input logic [TIME_W-1:0] want);
		if (got !== want)
			note_failure($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Order the loaded set by priority with a swapping selection sort, then queue one beat
	// per process with its running waiting and turnaround times.
	task automatic plan_schedule(input int n);
		int                 best;
		logic [IDX_W-1:0]   a;
		logic [IDX_W-1:0]   b;
		logic [BURST_W-1:0] tb;
		logic [PRIO_W-1:0]  tp;
		logic [ID_W-1:0]    ti;
		logic [SUM_W-1:0]   waiting;
		logic [SUM_W-1:0]   tat;
		logic [SUM_W-1:0]   wait_sum;
		logic [SUM_W-1:0]   tat_sum;
		logic [SUM_W-1:0]   avg_w;
		logic [SUM_W-1:0]   avg_t;
		sched_beat_t        beat;
		for (int i = 0; i < n; i++) begin
			best = i;
			for (int j = i + 1; j < n; j++)
				if (prio_slot[IDX_W'(j)] < prio_slot[IDX_W'(best)])
					best = j;
			a  = IDX_W'(i);
			b  = IDX_W'(best);
			tb = burst_slot[a]; burst_slot[a] = burst_slot[b]; burst_slot[b] = tb;
			tp = prio_slot[a];  prio_slot[a]  = prio_slot[b];  prio_slot[b]  = tp;
			ti = id_slot[a];    id_slot[a]    = id_slot[b];    id_slot[b]    = ti;
		end
		waiting  = '0;
		wait_sum = '0;
		tat_sum  = '0;
		for (int i = 0; i < n; i++) begin
			tat      = waiting + SUM_W'(burst_slot[IDX_W'(i)]);
			wait_sum = wait_sum + waiting;
			tat_sum  = tat_sum + tat;
			waiting  = tat;
		end
		avg_w   = wait_sum / SUM_W'(n);
		avg_t   = tat_sum / SUM_W'(n);
		waiting = '0;
		for (int i = 0; i < n; i++) begin
			a               = IDX_W'(i);
			tat             = waiting + SUM_W'(burst_slot[a]);
			beat.id         = id_slot[a];
			beat.burst      = burst_slot[a];
			beat.waiting    = waiting[TIME_W-1:0];
			beat.turnaround = tat[TIME_W-1:0];
			beat.last       = (i == n - 1);
			beat.avg_wait   = beat.last ? avg_w[TIME_W-1:0] : '0;
			beat.avg_turn   = beat.last ? avg_t[TIME_W-1:0] : '0;
			schedule_q.push_back(beat);
			waiting = tat;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded = 0;
			schedule_q.delete();
		end else begin
			// check result beats first, so a record loaded on the same edge cannot matter
			if (res_valid && res_ready) begin
				if (schedule_q.size() == 0) begin
					note_failure($sformatf("result beat with nothing expected, process_id %0d",
						process_id));
				end else begin
					head = schedule_q.pop_front();
					check_field("process_id", TIME_W'(process_id), TIME_W'(head.id));
					check_field("burst_out", TIME_W'(burst_out), TIME_W'(head.burst));
					check_field("waiting_time", waiting_time, head.waiting);
					check_field("turnaround_time", turnaround_time, head.turnaround);
					check_field("avg_waiting", avg_waiting, head.avg_wait);
					check_field("avg_turnaround", avg_turnaround, head.avg_turn);
					check_field("last_result", TIME_W'(last_result), TIME_W'(head.last));
				end
			end
			if (rec_valid && rec_ready) begin
				burst_slot[IDX_W'(loaded)] = burst_len;
				prio_slot[IDX_W'(loaded)]  = priority_level;
				id_slot[IDX_W'(loaded)]    = ID_W'(loaded + 1);
				loaded++;
				if (last_process || loaded == MAX_PROCS) begin
					plan_schedule(loaded);
					loaded = 0;
				end
			end
		end
		results_owed = schedule_q.size();
	end

	always @(posedge end_of_test)
		if (schedule_q.size() != 0)
			note_failure($sformatf("%0d result beats never arrived", schedule_q.size()));

endmodule

// ----- bench/priority_schedule_timing_core_tb.sv -----
// Top of the priority schedule timing core bench: clock, reset, record and result traffic, verdict.
`timescale 1ns / 1ps

module priority_schedule_timing_core_tb;
	import pst_pkg::*;

	// Boundaries of the idling phases, counted in accepted record beats.
	localparam int PHASE1_END  = 87;
	localparam int PHASE2_END  = 174;
	localparam int RECORD_GOAL = 260;
	localparam int HOLD_AT     = 120;
	localparam int HOLD_CYCLES = 1500;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                rec_valid;
	logic                rec_ready;
	logic [BURST_W-1:0]  burst_len;
	logic [PRIO_W-1:0]   priority_level;
	logic                last_process;
	logic                res_valid;
	logic                res_ready;
	logic [ID_W-1:0]     process_id;
	logic [BURST_W-1:0]  burst_out;
	logic [TIME_W-1:0]   waiting_time;
	logic [TIME_W-1:0]   turnaround_time;
	logic [TIME_W-1:0]   avg_waiting;
	logic [TIME_W-1:0]   avg_turnaround;
	logic                last_result;

	logic                end_of_test = 1'b0;
	int                  mismatches;
	int                  results_owed;
	int                  rec_beats;
	int                  records_offered = 0;

	always #5 clk = ~clk;

	priority_schedule_timing_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (rec_valid),
		.rec_ready      (rec_ready),
		.burst_len      (burst_len),
		.priority_level (priority_level),
		.last_process   (last_process),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.process_id     (process_id),
		.burst_out      (burst_out),
		.waiting_time   (waiting_time),
		.turnaround_time(turnaround_time),
		.avg_waiting    (avg_waiting),
		.avg_turnaround (avg_turnaround),
		.last_result    (last_result)
	);

	priority_schedule_timing_core_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (rec_valid),
		.rec_ready      (rec_ready),
		.burst_len      (burst_len),
		.priority_level (priority_level),
		.last_process   (last_process),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.process_id     (process_id),
		.burst_out      (burst_out),
		.waiting_time   (waiting_time),
		.turnaround_time(turnaround_time),
		.avg_waiting    (avg_waiting),
		.avg_turnaround (avg_turnaround),
		.last_result    (last_result),
		.end_of_test    (end_of_test),
		.mismatches     (mismatches),
		.results_owed   (results_owed)
	);

	// Count accepted record beats on the rising edge; the result-side process reads this at the
	// falling edge, so it does not depend on the order of processes within a step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rec_beats <= 0;
		else if (rec_valid && rec_ready)
			rec_beats <= rec_beats + 1;
	end

	// Sender idles lightly first, then heavily, then not at all.
	function automatic int sender_idle_pct(input int beats);
		if (beats < PHASE1_END)
			return 19;
		if (beats < PHASE2_END)
			return 63;
		return 0;
	endfunction

	// Receiver mirrors the sender: heavy first, light next, then never.
	function automatic int receiver_idle_pct(input int beats);
		if (beats < PHASE1_END)
			return 63;
		if (beats < PHASE2_END)
			return 19;
		return 0;
	endfunction

	// Offer one record beat. Entered and left at a falling edge; hold the payload
	// steady until the beat is taken.
	task automatic offer_record(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
		input logic mark_last);
		while ($urandom_range(99) < sender_idle_pct(records_offered)) begin
			rec_valid = 1'b0;
			@(negedge clk);
		end
		rec_valid      = 1'b1;
		burst_len      = burst;
		priority_level = prio;
		last_process   = mark_last;
		do
			@(posedge clk);
		while (!rec_ready);
		@(negedge clk);
		records_offered++;
	endtask

	// One random set. Full sets end on the store filling, with a random mark on the
	// filling record; shorter sets end on a marked record.
	task automatic offer_random_set();
		int                 size;
		bit                 narrow;
		logic [BURST_W-1:0] burst;
		logic               mark;
		size   = ($urandom_range(9) == 0) ? MAX_PROCS : $urandom_range(8, 1);
		narrow = 1'($urandom_range(1));
		for (int i = 0; i < size; i++) begin
			if ($urandom_range(3) == 0)
				burst = $urandom_range(1) ? '1 : '0;
			else
				burst = BURST_W'($urandom_range(16'hFFFF));
			if (i != size - 1)
				mark = 1'b0;
			else
				mark = (size == MAX_PROCS) ? 1'($urandom_range(1)) : 1'b1;
			// narrow priority spans crowd the ties that the swap order decides
			offer_record(burst, narrow ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255)),
				mark);
		end
	endtask

	// Result side: random stalls per phase, plus one long hold-off once the traffic is
	// well under way, so the block fills up and back-pressures the records.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && rec_beats >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready = 1'b0;
			end else begin
				res_ready = ($urandom_range(99) >= receiver_idle_pct(rec_beats));
			end
		end
	end

	// Main sequence: reset, directed sets, random sets, drain, verdict.
	initial begin
		int guard;
		arst_n         = 1'b0;
		rec_valid      = 1'b0;
		burst_len      = '0;
		priority_level = '0;
		last_process   = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-record sets at both extremes
		offer_record('0, '0, 1'b1);
		offer_record('1, '1, 1'b1);
		// short set with a three-way priority tie around a lower one
		offer_record(16'd100, 8'd5, 1'b0);
		offer_record('1, 8'd5, 1'b0);
		offer_record(16'd7, 8'd0, 1'b0);
		offer_record(16'd1, 8'd5, 1'b1);
		// full store with no mark: the filling record closes the set; largest sums
		for (int i = 0; i < MAX_PROCS; i++)
			offer_record('1, (i % 2) ? 8'hFF : 8'h00, 1'b0);

		while (records_offered < RECORD_GOAL)
			offer_random_set();
		rec_valid = 1'b0;

		// drain every owed beat, then let the block settle past its scheduling latency
		for (guard = 0; guard < 50000 && results_owed != 0; guard++)
			@(negedge clk);
		repeat (400) @(negedge clk);
		end_of_test = 1'b1;
		@(negedge clk);
		if (mismatches == 0) begin
			$display("priority_schedule_timing_core_tb passed");
		end else begin
			$display("priority_schedule_timing_core_tb failed");
		end
		$finish;
	end

	// Stop a hung run well past the slowest legal finish.
	initial begin
		#5_000_000;
		$display("priority_schedule_timing_core_tb failed");
		$finish;
	end

endmodule
